>>> sv/tti_pkg.sv
// Shared constants for the trilinear table interpolator.
package tti_pkg;

    localparam int COORD_W = 32;
    localparam int VAL_W = 32;
    localparam int SUM_W = 33;
    localparam int ADDR_W = 14;
    localparam int FRAC_W = 16;
    localparam int IDX_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CORNERS = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_INV_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_INV_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R_INV_STEP = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [31:0] INV_STEP_RESET = 32'd65536;

endpackage

>>> sv/trilinear_table_interpolator_unit.sv
// Throughput: one transaction per cycle while the output is not stalled; all eight
// corners of both tables are read in the same cycle from eight replicated memory banks
// per table, each serving one corner.
// Load transactions write all banks at the memory stage and produce no result.
// Reset clears the stage valid bits and origin registers and sets the inverse steps to
// INV_STEP_RESET; table contents stay undefined until loaded.
module trilinear_table_interpolator_unit
    import tti_pkg::*;
#(
    parameter int ALPHA_INTERVALS = 15,
    parameter int K_INTERVALS = 63,
    parameter int R_INTERVALS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [ADDR_W-1:0]           i_node_index,
    input  logic signed [VAL_W-1:0]     i_first_value,
    input  logic signed [VAL_W-1:0]     i_second_value,
    input  logic signed [COORD_W-1:0]   i_alpha_coord,
    input  logic signed [COORD_W-1:0]   i_k_coord,
    input  logic signed [COORD_W-1:0]   i_r_coord,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SUM_W-1:0]     o_interpolated_sum,
    output logic                        o_in_grid
);

    localparam int KN = K_INTERVALS + 1;
    localparam int RN = R_INTERVALS + 1;

    logic en;
    logic r_out_valid;

    logic signed [31:0] r_alpha_origin, r_k_origin, r_r_origin;
    logic [31:0] r_alpha_inv, r_k_inv, r_r_inv;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic r_cmd1, r_cmd2, r_cmd3, r_cmd4, r_cmd5, r_cmd6;
    logic [ADDR_W-1:0] r_laddr1, r_laddr2, r_laddr3;
    logic signed [VAL_W-1:0] r_lv1_1, r_lv1_2, r_lv1_3;
    logic signed [VAL_W-1:0] r_lv2_1, r_lv2_2, r_lv2_3;

    logic signed [32:0] r_d_a, r_d_k, r_d_r;
    logic [63:0] r_p_a, r_p_k, r_p_r;
    logic r_bad_a, r_bad_k, r_bad_r;

    logic [ADDR_W-1:0] r_addr3 [CORNERS];
    logic [FRAC_W-1:0] r_fa3, r_fk3, r_fr3, r_fa4, r_fk4, r_fr4, r_fa5, r_fr5, r_fr6;
    logic r_ua3, r_uk3, r_ur3, r_ua4, r_uk4, r_ur4, r_ua5, r_ur5, r_ur6;
    logic r_g3, r_g4, r_g5, r_g6;

    logic signed [VAL_W-1:0] r_rd_first [CORNERS];
    logic signed [VAL_W-1:0] r_rd_second [CORNERS];
    logic signed [VAL_W-1:0] r_ak_first [4], r_ak_second [4];
    logic signed [VAL_W-1:0] r_ar_first [2], r_ar_second [2];

    logic signed [SUM_W-1:0] r_sum;
    logic r_in_grid;

    logic [63:0] n_p_a, n_p_k, n_p_r;
    logic [IDX_W-1:0] n_lo_a, n_lo_k, n_lo_r;
    logic n_ua, n_uk, n_ur, n_g;
    logic signed [VAL_W-1:0] n_res_first, n_res_second;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W:0] a,
                                                 input logic [IDX_W:0] k,
                                                 input logic [IDX_W:0] r);
        logic [31:0] t;
        t = (32'(a) * 32'(KN) + 32'(k)) * 32'(RN) + 32'(r);
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] f_lerp(input logic signed [VAL_W-1:0] lo,
                                                       input logic signed [VAL_W-1:0] hi,
                                                       input logic [FRAC_W-1:0] f);
        logic [FRAC_W:0] wl;
        logic signed [49:0] lo_x, hi_x, wl_x, wh_x, acc;
        wl = 17'h10000 - {1'b0, f};
        lo_x = 50'(lo);
        hi_x = 50'(hi);
        wl_x = signed'(50'(wl));
        wh_x = signed'(50'(f));
        acc = lo_x * wl_x + hi_x * wh_x + 50'sd32768;
        return acc[47:16];
    endfunction

    assign en = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_out_valid;
    assign o_interpolated_sum = r_sum;
    assign o_in_grid = r_in_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_origin <= '0;
            r_k_origin <= '0;
            r_r_origin <= '0;
            r_alpha_inv <= INV_STEP_RESET;
            r_k_inv <= INV_STEP_RESET;
            r_r_inv <= INV_STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA_ORIGIN: r_alpha_origin <= i_cfg_data;
                CFG_K_ORIGIN: r_k_origin <= i_cfg_data;
                CFG_R_ORIGIN: r_r_origin <= i_cfg_data;
                CFG_ALPHA_INV_STEP: r_alpha_inv <= i_cfg_data;
                CFG_K_INV_STEP: r_k_inv <= i_cfg_data;
                CFG_R_INV_STEP: r_r_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_out_valid <= r_v6 && (r_cmd6 == CMD_QUERY);
        end
    end

    always_comb begin
        n_p_a = r_d_a[32] ? 64'd0 : 64'(r_d_a[31:0]) * 64'(r_alpha_inv);
        n_p_k = r_d_k[32] ? 64'd0 : 64'(r_d_k[31:0]) * 64'(r_k_inv);
        n_p_r = r_d_r[32] ? 64'd0 : 64'(r_d_r[31:0]) * 64'(r_r_inv);
        n_lo_a = r_p_a[32 +: IDX_W];
        n_lo_k = r_p_k[32 +: IDX_W];
        n_lo_r = r_p_r[32 +: IDX_W];
        n_ua = r_p_a[63:32] < 32'(ALPHA_INTERVALS);
        n_uk = r_p_k[63:32] < 32'(K_INTERVALS);
        n_ur = r_p_r[63:32] < 32'(R_INTERVALS);
        n_g = !r_bad_a && !r_bad_k && !r_bad_r
            && (r_p_a[63:32] <= 32'(ALPHA_INTERVALS))
            && (r_p_k[63:32] <= 32'(K_INTERVALS))
            && (r_p_r[63:32] <= 32'(R_INTERVALS));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1 <= i_command;
            r_laddr1 <= i_node_index;
            r_lv1_1 <= i_first_value;
            r_lv2_1 <= i_second_value;
            r_d_a <= 33'(i_alpha_coord) - 33'(r_alpha_origin);
            r_d_k <= 33'(i_k_coord) - 33'(r_k_origin);
            r_d_r <= 33'(i_r_coord) - 33'(r_r_origin);

            r_cmd2 <= r_cmd1;
            r_laddr2 <= r_laddr1;
            r_lv1_2 <= r_lv1_1;
            r_lv2_2 <= r_lv2_1;
            r_p_a <= n_p_a;
            r_p_k <= n_p_k;
            r_p_r <= n_p_r;
            r_bad_a <= r_d_a[32] && (r_alpha_inv != 32'd0);
            r_bad_k <= r_d_k[32] && (r_k_inv != 32'd0);
            r_bad_r <= r_d_r[32] && (r_r_inv != 32'd0);

            r_cmd3 <= r_cmd2;
            r_laddr3 <= r_laddr2;
            r_lv1_3 <= r_lv1_2;
            r_lv2_3 <= r_lv2_2;
            for (int b = 0; b < CORNERS; b++) begin
                r_addr3[b] <= f_addr({1'b0, n_lo_a} + (IDX_W + 1)'(b[1]),
                                     {1'b0, n_lo_k} + (IDX_W + 1)'(b[0]),
                                     {1'b0, n_lo_r} + (IDX_W + 1)'(b[2]));
            end
            r_fa3 <= n_ua ? r_p_a[31:16] : '0;
            r_fk3 <= n_uk ? r_p_k[31:16] : '0;
            r_fr3 <= n_ur ? r_p_r[31:16] : '0;
            r_ua3 <= n_ua;
            r_uk3 <= n_uk;
            r_ur3 <= n_ur;
            r_g3 <= n_g;

            r_cmd4 <= r_cmd3;
            r_fa4 <= r_fa3;
            r_fk4 <= r_fk3;
            r_fr4 <= r_fr3;
            r_ua4 <= r_ua3;
            r_uk4 <= r_uk3;
            r_ur4 <= r_ur3;
            r_g4 <= r_g3;

            r_cmd5 <= r_cmd4;
            r_fa5 <= r_fa4;
            r_fr5 <= r_fr4;
            r_ua5 <= r_ua4;
            r_ur5 <= r_ur4;
            r_g5 <= r_g4;
            for (int j = 0; j < 4; j++) begin
                r_ak_first[j] <= f_lerp(r_rd_first[2*j],
                    r_uk4 ? r_rd_first[2*j+1] : r_rd_first[2*j], r_fk4);
                r_ak_second[j] <= f_lerp(r_rd_second[2*j],
                    r_uk4 ? r_rd_second[2*j+1] : r_rd_second[2*j], r_fk4);
            end

            r_cmd6 <= r_cmd5;
            r_fr6 <= r_fr5;
            r_ur6 <= r_ur5;
            r_g6 <= r_g5;
            for (int j = 0; j < 2; j++) begin
                r_ar_first[j] <= f_lerp(r_ak_first[2*j],
                    r_ua5 ? r_ak_first[2*j+1] : r_ak_first[2*j], r_fa5);
                r_ar_second[j] <= f_lerp(r_ak_second[2*j],
                    r_ua5 ? r_ak_second[2*j+1] : r_ak_second[2*j], r_fa5);
            end

            r_sum <= r_g6 ? (33'(n_res_first) + 33'(n_res_second)) : '0;
            r_in_grid <= r_g6;
        end
    end

    always_comb begin
        n_res_first = f_lerp(r_ar_first[0], r_ur6 ? r_ar_first[1] : r_ar_first[0], r_fr6);
        n_res_second = f_lerp(r_ar_second[0], r_ur6 ? r_ar_second[1] : r_ar_second[0],
                              r_fr6);
    end

    for (genvar b = 0; b < CORNERS; b++) begin : g_bank
        logic signed [VAL_W-1:0] r_first_mem [STORE_DEPTH];
        logic signed [VAL_W-1:0] r_second_mem [STORE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (en && r_v3 && (r_cmd3 == CMD_LOAD)) begin
                r_first_mem[r_laddr3] <= r_lv1_3;
                r_second_mem[r_laddr3] <= r_lv2_3;
            end
            if (en) begin
                r_rd_first[b] <= r_first_mem[r_addr3[b]];
                r_rd_second[b] <= r_second_mem[r_addr3[b]];
            end
        end
    end

endmodule

>>> sv/tti_checker.sv
// Port-level checker for the trilinear table interpolator, with its bind.
module tti_port_checker
    import tti_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [SUM_W-1:0] o_interpolated_sum,
    input logic                    o_in_grid
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_interpolated_sum))
        else $error("Stalled result changed.");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("Input stalled without an output stall.");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_grid |-> o_interpolated_sum == '0)
        else $error("Off-grid result is not zero.");

endmodule

bind trilinear_table_interpolator_unit tti_port_checker u_tti_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_interpolated_sum(o_interpolated_sum),
    .o_in_grid(o_in_grid)
);
